@@ src/fsla_pkg.sv @@
// ----------------------------------------------------------------------------
// Free list allocator package
// Sizes, codes and item layouts shared by the pool allocator files.
// ----------------------------------------------------------------------------
package fsla_pkg;

	localparam int MAX_OBJECTS  = 64;
	localparam int HEADER_BYTES = 32;

	localparam int IDX_W    = $clog2(MAX_OBJECTS);
	localparam int LINK_W   = IDX_W + 1;
	localparam int REGION_W = 16;
	localparam int OBJ_W    = 13;
	localparam int OFF_W    = 22;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;

	localparam int REGION_RESET = 256;
	localparam int OBJ_RESET    = 24;

	localparam int OUT_BITS    = IDX_W + OFF_W + STATUS_W + 1 + LINK_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int IN_TDATA_W  = ((IDX_W + 7) / 8) * 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_FREE    = 2'd1,
		MODE_REBUILD = 2'd2,
		MODE_PEEK    = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_SMALL = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic {
		REG_REGION = 1'b0,
		REG_OBJECT = 1'b1
	} reg_idx_t;

endpackage

@@ src/fsla_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module fsla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/fixed_size_free_list_allocator_top.sv @@
// ----------------------------------------------------------------------------
// Fixed-size free list pool allocator
// LIFO free list of equal objects behind a fixed header, links held in RAM.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          contents
//  s_*       in   tvalid/tready      tuser mode, tdata object_index
//  m_*       out  tvalid/tready      tdata index, offset, status, empty, total
//  apb       in   psel/penable       region_bytes at 0x0, object_bytes at 0x4
//
// Alloc passes through S_ALLOC, as the link of the head comes from the
// registered read of the link RAM. Free, peek and flagged items are answered
// from S_IDLE. Rebuild runs an 8-step divider, then one link write per object;
// a quotient of 128 or more ends the divider after its top step, and a zero
// object size or a region too small skips it. arst_n empties the list but
// not the link RAM. A stalled result holds the next item off until it leaves.
// ----------------------------------------------------------------------------
module fixed_size_free_list_allocator_top
	import fsla_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// s_tdata: object_index [5:0], zero pad above
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// s_tuser: mode [1:0]
	input  logic [MODE_W-1:0]      s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// m_tdata: result_index [5:0], byte_offset [27:6], status [29:28],
	// pool_empty [30], object_total [37:31], zero pad above
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int SHIFT_W = OBJ_W + LINK_W;
	localparam int KW      = $clog2(LINK_W + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ALLOC,
		S_DIV,
		S_FILL
	} state_t;

	state_t                 state_q;
	logic [LINK_W-1:0]      head_q;
	logic [LINK_W-1:0]      pool_count_q;
	logic [OBJ_W-1:0]       obj_latched_q;
	logic [REGION_W-1:0]    num_q;
	logic [OBJ_W-1:0]       den_q;
	logic [KW-1:0]          k_q;
	logic [LINK_W-1:0]      quot_q;
	logic [LINK_W-1:0]      count_q;
	logic [LINK_W-1:0]      fill_q;
	logic [REGION_W-1:0]    region_q;
	logic [OBJ_W-1:0]       objb_q;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic                   out_free;
	logic                   in_acc;
	mode_t                  in_mode;
	logic [IDX_W-1:0]       in_idx;
	logic                   head_ok;
	logic                   free_in_range;

	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [LINK_W-1:0]      ram_wdata;
	logic [LINK_W-1:0]      ram_rdata;

	logic                   emit_en;
	logic [IDX_W-1:0]       e_idx;
	logic                   e_off_ok;
	status_t                e_status;
	logic [LINK_W-1:0]      e_head;
	logic [LINK_W-1:0]      e_total;
	logic [IDX_W+OBJ_W-1:0] prod;
	logic [OFF_W-1:0]       e_off;
	logic                   e_empty;

	logic [SHIFT_W-1:0]     shifted;
	logic                   div_ge;
	logic [LINK_W-1:0]      quot_next;
	logic [LINK_W-1:0]      quot_cap;
	logic [LINK_W-1:0]      fill_inc;

	reg_idx_t               cfg_idx;
	logic                   cfg_we;

	// ---------------------------------------------------------------- config
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[2]);
	assign cfg_we  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (cfg_idx)
			REG_REGION: prdata = 32'(region_q);
			REG_OBJECT: prdata = 32'(objb_q);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= REGION_W'(REGION_RESET);
			objb_q   <= OBJ_W'(OBJ_RESET);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_REGION: region_q <= pwdata[REGION_W-1:0];
				REG_OBJECT: objb_q   <= pwdata[OBJ_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ handshakes
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign in_acc   = s_tvalid && s_tready;
	assign in_mode  = mode_t'(s_tuser);
	assign in_idx   = s_tdata[IDX_W-1:0];
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign head_ok       = head_q < LINK_W'(MAX_OBJECTS);
	assign free_in_range = {1'b0, in_idx} < pool_count_q;

	// ------------------------------------------------------------ link RAM
	assign fill_inc = fill_q + LINK_W'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = in_idx;
		ram_wdata = head_q;
		if (state_q == S_IDLE) begin
			ram_we = in_acc && (in_mode == MODE_FREE) && free_in_range;
		end else if (state_q == S_FILL) begin
			ram_we    = fill_q < count_q;
			ram_waddr = fill_q[IDX_W-1:0];
			ram_wdata = (fill_inc < count_q) ? fill_inc : LINK_W'(MAX_OBJECTS);
		end
	end

	fsla_ram #(
		.WIDTH(LINK_W),
		.DEPTH(MAX_OBJECTS)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(head_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	// ------------------------------------------------------------- divider
	// Restoring division of (region - header) by the object size, one
	// quotient bit a cycle. The top step only detects a quotient too large
	// to count, which saturates to the pool depth.
	assign shifted   = SHIFT_W'(den_q) << k_q;
	assign div_ge    = SHIFT_W'(num_q) >= shifted;
	assign quot_next = div_ge ? (quot_q | (LINK_W'(1) << k_q)) : quot_q;
	assign quot_cap  = (quot_next > LINK_W'(MAX_OBJECTS)) ? LINK_W'(MAX_OBJECTS) : quot_next;

	// --------------------------------------------------------------- result
	always_comb begin
		emit_en  = 1'b0;
		e_idx    = '0;
		e_off_ok = 1'b0;
		e_status = STAT_OK;
		e_head   = head_q;
		e_total  = pool_count_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					unique case (in_mode)
						MODE_ALLOC: begin
							if (!head_ok) begin
								emit_en  = 1'b1;
								e_status = STAT_EMPTY;
							end
						end
						MODE_FREE: begin
							emit_en = 1'b1;
							e_idx   = in_idx;
							if (free_in_range) begin
								e_off_ok = 1'b1;
								e_head   = {1'b0, in_idx};
							end else begin
								e_status = STAT_RANGE;
							end
						end
						MODE_REBUILD: ;
						MODE_PEEK: begin
							emit_en = 1'b1;
							if (head_ok) begin
								e_idx    = head_q[IDX_W-1:0];
								e_off_ok = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_ALLOC: begin
				if (out_free) begin
					emit_en  = 1'b1;
					e_idx    = head_q[IDX_W-1:0];
					e_off_ok = 1'b1;
					e_head   = ram_rdata;
				end
			end
			S_DIV: ;
			S_FILL: begin
				if (fill_q == count_q && out_free) begin
					emit_en = 1'b1;
					if (count_q == '0) begin
						e_status = STAT_SMALL;
						e_head   = LINK_W'(MAX_OBJECTS);
						e_total  = '0;
					end else begin
						e_off_ok = 1'b1;
						e_head   = '0;
						e_total  = count_q;
					end
				end
			end
			default: ;
		endcase
	end

	assign prod    = {{OBJ_W{1'b0}}, e_idx} * {{IDX_W{1'b0}}, obj_latched_q};
	assign e_off   = e_off_ok ? (OFF_W'(HEADER_BYTES) + OFF_W'(prod)) : '0;
	assign e_empty = e_head >= LINK_W'(MAX_OBJECTS);

	// -------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			head_q        <= LINK_W'(MAX_OBJECTS);
			pool_count_q  <= '0;
			obj_latched_q <= OBJ_W'(OBJ_RESET);
			k_q           <= '0;
			fill_q        <= '0;
			count_q       <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (emit_en) begin
				head_q       <= e_head;
				pool_count_q <= e_total;
				m_tvalid_q   <= 1'b1;
				m_tdata_q    <= OUT_TDATA_W'({e_total, e_empty, e_status, e_off, e_idx});
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc && in_mode == MODE_ALLOC && head_ok) begin
						state_q <= S_ALLOC;
					end else if (in_acc && in_mode == MODE_REBUILD) begin
						den_q <= objb_q;
						if (objb_q == '0 || region_q < REGION_W'(HEADER_BYTES)) begin
							count_q <= '0;
							fill_q  <= '0;
							state_q <= S_FILL;
						end else begin
							num_q   <= region_q - REGION_W'(HEADER_BYTES);
							k_q     <= KW'(LINK_W);
							quot_q  <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_ALLOC: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (k_q == KW'(LINK_W)) begin
						if (div_ge) begin
							count_q <= LINK_W'(MAX_OBJECTS);
							fill_q  <= '0;
							state_q <= S_FILL;
						end else begin
							k_q <= k_q - KW'(1);
						end
					end else begin
						if (div_ge) begin
							num_q <= num_q - shifted[REGION_W-1:0];
						end
						quot_q <= quot_next;
						if (k_q == '0) begin
							count_q <= quot_cap;
							fill_q  <= '0;
							state_q <= S_FILL;
						end else begin
							k_q <= k_q - KW'(1);
						end
					end
				end
				S_FILL: begin
					if (fill_q < count_q) begin
						fill_q <= fill_inc;
					end else if (out_free) begin
						if (count_q != '0) begin
							obj_latched_q <= den_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_head_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		head_q == LINK_W'(MAX_OBJECTS) || head_q < pool_count_q)
		else $error("free list head outside the pool");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		pool_count_q <= LINK_W'(MAX_OBJECTS))
		else $error("pool count above depth");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL |-> fill_q <= count_q)
		else $error("link fill ran past the object count");

	a_alloc_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC && out_free) |=> (state_q == S_IDLE && m_tvalid))
		else $error("alloc did not complete with a result");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV || state_q == S_FILL) |-> !s_tready)
		else $error("item taken during rebuild");
`endif

endmodule

@@ tb/fixed_size_free_list_allocator_top_tb.sv @@
// ----------------------------------------------------------------------------
// Pool allocator testbench
// Drives alloc, free, rebuild and peek items into the free list allocator,
// programs the region and object sizes over APB between phases, and checks
// every reply against a behavioral copy of the pool kept in this file.
// ----------------------------------------------------------------------------
module fixed_size_free_list_allocator_top_tb;
	import fsla_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 2 + 8 + MAX_OBJECTS + 16;
	localparam logic [31:0] REGION_MASK = (32'd1 << REGION_W) - 1;
	localparam logic [31:0] OBJ_MASK    = (32'd1 << OBJ_W) - 1;

	// One reply item as it sits in m_tdata, lowest field last.
	typedef struct packed {
		logic [LINK_W-1:0] total;
		logic              empty;
		status_t           status;
		logic [OFF_W-1:0]  offset;
		logic [IDX_W-1:0]  index;
	} pool_reply_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// object_index [5:0], zero pad above
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	// mode [1:0]
	logic [MODE_W-1:0]      s_tuser = MODE_PEEK;
	logic                   m_tvalid;
	logic                   m_tready = 1'b1;
	// result_index [5:0], byte_offset [27:6], status [29:28], pool_empty [30],
	// object_total [37:31], zero pad above
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [2:0]             paddr = '0;
	logic [31:0]            pwdata = '0;
	logic [31:0]            prdata;
	logic                   pready;

	// Behavioral copy of the pool.
	logic [LINK_W-1:0]   link_ram [MAX_OBJECTS];
	logic [LINK_W-1:0]   free_head = LINK_W'(MAX_OBJECTS);
	logic [LINK_W-1:0]   pool_count = '0;
	logic [REGION_W-1:0] region_reg = REGION_W'(REGION_RESET);
	logic [OBJ_W-1:0]    obj_reg = OBJ_W'(OBJ_RESET);
	logic [OBJ_W-1:0]    obj_latched = OBJ_W'(OBJ_RESET);

	pool_reply_t      expected_replies [$];
	pool_reply_t      seen_reply;
	pool_reply_t      oldest_reply;
	logic [IDX_W-1:0] held_objects [$];
	int               mismatch_count = 0;
	int               cycle_count = 0;
	int               burst_left = 0;
	int               stall_kind = 0;
	int               stall_run = 0;

	fixed_size_free_list_allocator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [OFF_W-1:0] object_offset(logic [IDX_W-1:0] idx);
		int unsigned off;
		off = HEADER_BYTES + int'(idx) * int'(obj_latched);
		return off[OFF_W-1:0];
	endfunction

	// Advances the pool copy by one item and returns the reply it must give.
	function automatic pool_reply_t predict_pool_reply(mode_t mode, logic [IDX_W-1:0] idx);
		pool_reply_t r;
		int unsigned cnt;
		r = '0;
		r.status = STAT_OK;
		case (mode)
			MODE_ALLOC: begin
				if (free_head >= MAX_OBJECTS) begin
					r.status = STAT_EMPTY;
				end else begin
					r.index = free_head[IDX_W-1:0];
					r.offset = object_offset(r.index);
					free_head = link_ram[r.index];
				end
			end
			MODE_FREE: begin
				r.index = idx;
				if (idx >= pool_count) begin
					r.status = STAT_RANGE;
				end else begin
					link_ram[idx] = free_head;
					free_head = LINK_W'(idx);
					r.offset = object_offset(idx);
				end
			end
			MODE_REBUILD: begin
				cnt = 0;
				if (obj_reg != 0 && region_reg >= HEADER_BYTES) begin
					cnt = (int'(region_reg) - HEADER_BYTES) / int'(obj_reg);
					if (cnt > MAX_OBJECTS)
						cnt = MAX_OBJECTS;
				end
				if (cnt == 0) begin
					pool_count = '0;
					free_head = LINK_W'(MAX_OBJECTS);
					r.status = STAT_SMALL;
				end else begin
					obj_latched = obj_reg;
					pool_count = LINK_W'(cnt);
					for (int i = 0; i < cnt; i++)
						link_ram[i] = (i + 1 < cnt) ? LINK_W'(i + 1) : LINK_W'(MAX_OBJECTS);
					free_head = '0;
					r.offset = object_offset('0);
				end
			end
			default: begin
				if (free_head < MAX_OBJECTS) begin
					r.index = free_head[IDX_W-1:0];
					r.offset = object_offset(r.index);
				end
			end
		endcase
		r.empty = (free_head >= MAX_OBJECTS);
		r.total = pool_count;
		return r;
	endfunction

	function automatic void compare_field(string field, longint unsigned want_v,
			longint unsigned got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", field, want_v, got_v);
			mismatch_count++;
		end
	endfunction

	// Reply checker.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_reply = pool_reply_t'(m_tdata[OUT_BITS-1:0]);
			if (expected_replies.size() == 0) begin
				$error("reply: expected none, got index %0d status %0d",
					seen_reply.index, seen_reply.status);
				mismatch_count++;
			end else begin
				oldest_reply = expected_replies.pop_front();
				compare_field("result_index", oldest_reply.index, seen_reply.index);
				compare_field("byte_offset", oldest_reply.offset, seen_reply.offset);
				compare_field("status", oldest_reply.status, seen_reply.status);
				compare_field("pool_empty", oldest_reply.empty, seen_reply.empty);
				compare_field("object_total", oldest_reply.total, seen_reply.total);
			end
		end
	end

	// The receiver switches between always ready, coin flips, rare readiness
	// and a fixed one-in-five stall, each for a random stretch.
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_kind <= $urandom_range(0, 3);
			stall_run <= $urandom_range(8, 64);
		end else begin
			stall_run <= stall_run - 1;
		end
		case (stall_kind)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 1) != 0);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ((cycle_count % 5) != 0);
		endcase
	end

	// Leaves tvalid high on return so that back-to-back items need no toggle.
	task automatic send_item(mode_t mode, logic [IDX_W-1:0] idx, output pool_reply_t reply);
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= IN_TDATA_W'(idx);
		do @(posedge clk); while (!s_tready);
		reply = predict_pool_reply(mode, idx);
		expected_replies.push_back(reply);
	endtask

	task automatic send(mode_t mode, logic [IDX_W-1:0] idx = '0);
		pool_reply_t reply;
		send_item(mode, idx, reply);
	endtask

	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain_replies();
		s_tvalid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
	endtask

	// Writes one register, then reads it back. Only called with the pool idle.
	task automatic program_register(reg_idx_t which, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (which == REG_REGION)
			region_reg = value[REGION_W-1:0];
		else
			obj_reg = value[OBJ_W-1:0];
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		compare_field("prdata", value & ((which == REG_REGION) ? REGION_MASK : OBJ_MASK),
			prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure_pool(logic [31:0] region, logic [31:0] obj);
		drain_replies();
		program_register(REG_REGION, region);
		program_register(REG_OBJECT, obj);
	endtask

	// Nothing has been built yet: every operation sees an empty pool.
	task automatic test_empty_pool();
		send(MODE_PEEK);
		send(MODE_ALLOC);
		send(MODE_FREE, 6'd0);
	endtask

	// Reset sizes give nine objects; a double free makes one index come back
	// on every alloc.
	task automatic test_default_rebuild();
		send(MODE_REBUILD);
		send(MODE_ALLOC);
		send(MODE_ALLOC);
		send(MODE_ALLOC);
		send(MODE_FREE, 6'd1);
		send(MODE_FREE, 6'd1);
		send(MODE_PEEK);
		send(MODE_ALLOC);
		send(MODE_ALLOC);
	endtask

	// A new object size only takes effect at the next rebuild.
	task automatic test_latched_size();
		configure_pool(REGION_RESET, 100);
		send(MODE_ALLOC);
	endtask

	task automatic test_size_extremes();
		configure_pool(16'hFFFF, 1);
		send(MODE_REBUILD);
		send(MODE_FREE, 6'd63);
		send(MODE_ALLOC);
		configure_pool(16'hFFFF, 4096);
		send(MODE_REBUILD);
		send(MODE_ALLOC);
		configure_pool(HEADER_BYTES + 4096, 4096);
		send(MODE_REBUILD);
		send(MODE_ALLOC);
		send(MODE_ALLOC);
		send(MODE_FREE, 6'd1);
		send(MODE_FREE, 6'd0);
		configure_pool(HEADER_BYTES - 1, 1);
		send(MODE_REBUILD);
		send(MODE_ALLOC);
		configure_pool(HEADER_BYTES, 1);
		send(MODE_REBUILD);
		configure_pool(0, 0);
		send(MODE_REBUILD);
	endtask

	// Phases of rebuild followed by mostly allocs and frees of held objects,
	// with stray frees, peeks and mid-phase rebuilds mixed in.
	task automatic test_random_traffic(int n_items);
		int sent;
		int phase_len;
		int alloc_pct;
		int pick;
		int cnt;
		int hits [$];
		logic [31:0] obj;
		logic [31:0] region;
		logic [IDX_W-1:0] idx;
		mode_t mode;
		pool_reply_t reply;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 9);
			if (pick < 5)
				obj = $urandom_range(1, 64);
			else if (pick < 8)
				obj = $urandom_range(65, 4096);
			else
				obj = ($urandom_range(0, 1) != 0) ? 1 : 4096;
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				cnt = $urandom_range(1, 8);
				region = HEADER_BYTES + cnt * obj + $urandom_range(0, obj - 1);
				if (region > 32'hFFFF)
					region = 32'hFFFF;
			end else if (pick < 8) begin
				region = $urandom_range(0, 16'hFFFF);
			end else begin
				case ($urandom_range(0, 3))
					0: region = 0;
					1: region = HEADER_BYTES - 1;
					2: region = HEADER_BYTES;
					default: region = 16'hFFFF;
				endcase
			end
			configure_pool(region, obj);
			send(MODE_REBUILD);
			held_objects.delete();
			sent++;
			phase_len = $urandom_range(8, 60);
			alloc_pct = $urandom_range(40, 80);
			repeat (phase_len) begin
				pace_sender();
				pick = $urandom_range(0, 99);
				idx = IDX_W'($urandom_range(0, MAX_OBJECTS - 1));
				if (pick < alloc_pct) begin
					mode = MODE_ALLOC;
				end else if (pick < 94) begin
					mode = MODE_FREE;
					if (held_objects.size() != 0 && $urandom_range(0, 99) < 85)
						idx = held_objects[$urandom_range(0, held_objects.size() - 1)];
				end else if (pick < 97) begin
					mode = MODE_PEEK;
				end else begin
					mode = MODE_REBUILD;
				end
				send_item(mode, idx, reply);
				sent++;
				if (mode == MODE_REBUILD) begin
					held_objects.delete();
				end else if (mode == MODE_ALLOC && reply.status == STAT_OK) begin
					held_objects.push_back(reply.index);
				end else if (mode == MODE_FREE && reply.status == STAT_OK) begin
					hits = held_objects.find_first_index(h) with (h == idx);
					if (hits.size() != 0)
						held_objects.delete(hits[0]);
				end
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_pool();
		test_default_rebuild();
		test_latched_size();
		test_size_extremes();
		test_random_traffic(800);
		drain_replies();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
src/fsla_pkg.sv
src/fsla_ram.sv
src/fixed_size_free_list_allocator_top.sv
tb/fixed_size_free_list_allocator_top_tb.sv
